/* design/slen_pkg.sv */
`default_nettype none
package slen_pkg;

    localparam int CAPACITY    = 64;
    localparam int AW          = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW          = $clog2(CAPACITY + 1);
    localparam int POS_W       = 7;
    localparam int CMP_W       = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam int DATA_W      = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QAW         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_LOCATE = 2'd2;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_LOCATE = 2'd2;
    localparam logic [1:0] OP_REJECT = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BADPOS   = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [1:0]              kind;
        logic [POS_W-1:0]        position;
        logic signed [DATA_W-1:0] value;
    } t_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [POS_W-1:0] found_position;
        logic [POS_W-1:0] list_length;
    } t_result;

    typedef struct packed {
        logic [1:0]        op;
        logic              pos_zero;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] value;
    } t_cmd;

endpackage
`default_nettype wire

/* design/sequential_list_engine.sv */
// An accepted word goes through the front staging register and the queue to the back end;
// there an insert shifts the entries from the tail down to its slot, a delete those after it,
// a locate scans from the head to a match or the tail; rejected or trivial words skip the walk.
// The back end pops the next queued word only when idle, so the store walk sets throughput.
// Each result is strobed for one cycle on o_done; the receiver cannot stall it.
// Synchronous active-low reset empties the list and queue; store contents are not cleared.
`default_nettype none
module sequential_list_engine
    import slen_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  start,
    input  wire t_item i_item,
    output logic       busy,
    output logic       o_done,
    output t_result    o_result
);

    logic push;
    t_cmd push_cmd;
    logic full;
    logic head_valid;
    t_cmd head_cmd;
    logic pop;

    slen_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (i_item),
        .o_busy  (busy),
        .o_push  (push),
        .o_cmd   (push_cmd),
        .i_full  (full)
    );

    slen_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (full),
        .o_valid (head_valid),
        .o_data  (head_cmd),
        .i_pop   (pop)
    );

    slen_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (head_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_done      (o_done),
        .o_result    (o_result)
    );

endmodule
`default_nettype wire

/* design/slen_front.sv */
`default_nettype none
module slen_front
    import slen_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire t_item i_item,
    output logic       o_busy,
    output logic       o_push,
    output t_cmd       o_cmd,
    input  wire logic  i_full
);

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic accept;

    // The staging word drains into the queue whenever the queue has room.
    assign o_push = r_valid && !i_full;
    assign o_busy = r_valid && i_full;
    assign o_cmd  = r_cmd;
    assign accept = i_start && !o_busy;

    always_comb begin
        n_valid = r_valid && i_full;
        n_cmd   = r_cmd;
        if (accept) begin
            n_valid        = 1'b1;
            n_cmd.position = i_item.position;
            n_cmd.value    = i_item.value;
            n_cmd.pos_zero = (i_item.position == '0);
            unique case (i_item.kind)
                KIND_INSERT: n_cmd.op = OP_INSERT;
                KIND_DELETE: n_cmd.op = OP_DELETE;
                KIND_LOCATE: n_cmd.op = OP_LOCATE;
                default:     n_cmd.op = OP_REJECT;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end

endmodule
`default_nettype wire

/* design/slen_queue.sv */
`default_nettype none
module slen_queue
    import slen_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_data,
    output logic      o_full,
    output logic      o_valid,
    output t_cmd      o_data,
    input  wire logic i_pop
);

    t_cmd           r_mem [QUEUE_DEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0]   r_fill;

    assign o_full  = (r_fill == (QAW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QAW'(1);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + (QAW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - (QAW+1)'(1);
            end
        end
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule
`default_nettype wire

/* design/slen_back.sv */
`default_nettype none
module slen_back
    import slen_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_pop,
    output logic      o_done,
    output t_result   o_result
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_INS_SHIFT = 3'd1;
    localparam logic [2:0] S_INS_PUT   = 3'd2;
    localparam logic [2:0] S_DEL_SHIFT = 3'd3;
    localparam logic [2:0] S_LOC_SCAN  = 3'd4;

    logic [DATA_W-1:0] r_mem [CAPACITY];
    logic [DATA_W-1:0] r_rd_data;

    logic [2:0]    r_state;
    logic [2:0]    n_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [AW-1:0] r_ptr;
    logic [AW-1:0] n_ptr;
    t_cmd          r_cmd;
    t_cmd          n_cmd;
    logic          r_done;
    logic          n_done;
    t_result       r_result;
    t_result       n_result;

    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;

    logic [CMP_W-1:0] cnt_c;
    logic [CMP_W-1:0] head_pos_c;
    logic [CMP_W-1:0] cur_pos_c;
    logic [AW-1:0]    head_idx;
    logic [AW-1:0]    cur_idx;
    logic [AW-1:0]    last_idx;

    assign cnt_c      = CMP_W'(r_count);
    assign head_pos_c = CMP_W'(i_cmd.position);
    assign cur_pos_c  = CMP_W'(r_cmd.position);
    assign head_idx   = AW'(head_pos_c - CMP_W'(1));
    assign cur_idx    = AW'(cur_pos_c - CMP_W'(1));
    assign last_idx   = AW'(cnt_c - CMP_W'(1));

    assign o_pop    = (r_state == S_IDLE) && i_cmd_valid;
    assign o_done   = r_done;
    assign o_result = r_result;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ptr    = r_ptr;
        n_cmd    = r_cmd;
        n_done   = 1'b0;
        n_result = '0;
        rd_en    = 1'b0;
        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_addr  = '0;
        wr_data  = r_cmd.value;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd = i_cmd;
                    unique case (i_cmd.op)
                        OP_INSERT: begin
                            if (i_cmd.pos_zero || head_pos_c > cnt_c + CMP_W'(1)
                                    || cnt_c >= CMP_W'(CAPACITY)) begin
                                n_done          = 1'b1;
                                n_result.status = ST_BADPOS;
                            end else if (head_pos_c <= cnt_c) begin
                                // Entries from the tail down to the slot move up one.
                                rd_en   = 1'b1;
                                rd_addr = last_idx;
                                n_ptr   = last_idx;
                                n_state = S_INS_SHIFT;
                            end else begin
                                wr_en           = 1'b1;
                                wr_addr         = head_idx;
                                wr_data         = i_cmd.value;
                                n_count         = r_count + CW'(1);
                                n_done          = 1'b1;
                                n_result.status = ST_OK;
                            end
                        end
                        OP_DELETE: begin
                            if (r_count == '0) begin
                                n_done          = 1'b1;
                                n_result.status = ST_EMPTY;
                            end else if (i_cmd.pos_zero || head_pos_c > cnt_c) begin
                                n_done          = 1'b1;
                                n_result.status = ST_BADPOS;
                            end else if (head_pos_c == cnt_c) begin
                                n_count         = r_count - CW'(1);
                                n_done          = 1'b1;
                                n_result.status = ST_OK;
                            end else begin
                                // Read the entry just after the removed one.
                                rd_en   = 1'b1;
                                rd_addr = AW'(head_pos_c);
                                n_ptr   = AW'(head_pos_c);
                                n_state = S_DEL_SHIFT;
                            end
                        end
                        OP_LOCATE: begin
                            if (r_count == '0) begin
                                n_done          = 1'b1;
                                n_result.status = ST_NOTFOUND;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = '0;
                                n_ptr   = '0;
                                n_state = S_LOC_SCAN;
                            end
                        end
                        default: begin
                            n_done          = 1'b1;
                            n_result.status = ST_BADPOS;
                        end
                    endcase
                end
            end
            S_INS_SHIFT: begin
                wr_en   = 1'b1;
                wr_addr = r_ptr + AW'(1);
                wr_data = r_rd_data;
                if (r_ptr == cur_idx) begin
                    n_state = S_INS_PUT;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_ptr - AW'(1);
                    n_ptr   = r_ptr - AW'(1);
                end
            end
            S_INS_PUT: begin
                wr_en           = 1'b1;
                wr_addr         = cur_idx;
                wr_data         = r_cmd.value;
                n_count         = r_count + CW'(1);
                n_done          = 1'b1;
                n_result.status = ST_OK;
                n_state         = S_IDLE;
            end
            S_DEL_SHIFT: begin
                wr_en   = 1'b1;
                wr_addr = r_ptr - AW'(1);
                wr_data = r_rd_data;
                if (r_ptr == last_idx) begin
                    n_count         = r_count - CW'(1);
                    n_done          = 1'b1;
                    n_result.status = ST_OK;
                    n_state         = S_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_ptr + AW'(1);
                    n_ptr   = r_ptr + AW'(1);
                end
            end
            S_LOC_SCAN: begin
                if (r_rd_data == r_cmd.value) begin
                    n_done                  = 1'b1;
                    n_result.status         = ST_OK;
                    n_result.found_position = POS_W'(CMP_W'(r_ptr) + CMP_W'(1));
                    n_state                 = S_IDLE;
                end else if (r_ptr == last_idx) begin
                    n_done          = 1'b1;
                    n_result.status = ST_NOTFOUND;
                    n_state         = S_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_ptr + AW'(1);
                    n_ptr   = r_ptr + AW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_result.list_length = POS_W'(CMP_W'(n_count));
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
        r_ptr    <= n_ptr;
        r_cmd    <= n_cmd;
        r_result <= n_result;
    end

endmodule
`default_nettype wire
